@@ rtl/sld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length frame deframer package
// Shared constants, codes and types of the per-channel frame deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_PAYLOAD  = 32;
    localparam int NUM_CHANNELS = 3;

    localparam int CH_W       = 2;
    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BYTE_W     = 8;
    localparam int CHECK_W    = 16;
    localparam int CNT_W      = 6;
    localparam int TIMER_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MEM_DEPTH = NUM_CHANNELS * MAX_PAYLOAD;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd2;

    localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ID     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHK_HI = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CHK_LO = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [BYTE_W-1:0]  SYNC_RESET    = 8'h55;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CH_W-1:0]     channel;
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   id;
        logic [BYTE_W-1:0]   length;
        logic [CHECK_W-1:0]  check;
        logic [CNT_W-1:0]    n_pay;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                    full;
        logic                    empty;
        logic [NUM_CHANNELS-1:0] chan_mask;
    } q_stat_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_IDX_W-1:0] ch,
                                                  input logic [CNT_W-1:0] idx);
        mem_addr = ADDR_W'(ch) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/sld_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length frame deframer channels
// Valid/ready interfaces for received items and for result items.
// ----------------------------------------------------------------------------
interface sld_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [sld_pkg::CH_W-1:0]      channel;
    logic [sld_pkg::BYTE_W-1:0]    byte_value;

    modport source (output valid, output kind, output channel, output byte_value,
                    input ready);
    modport sink (input valid, input kind, input channel, input byte_value,
                  output ready);
endinterface

interface sld_out_if;
    logic                          valid;
    logic                          ready;
    logic [sld_pkg::STATUS_W-1:0]  status;
    logic [sld_pkg::CH_W-1:0]      out_channel;
    logic [sld_pkg::BYTE_W-1:0]    command_code;
    logic [sld_pkg::BYTE_W-1:0]    frame_id;
    logic [sld_pkg::BYTE_W-1:0]    payload_length;
    logic [sld_pkg::CHECK_W-1:0]   check_word;
    logic [sld_pkg::BYTE_W-1:0]    payload_byte;
    logic                          last;

    modport source (output valid, output status, output out_channel,
                    output command_code, output frame_id, output payload_length,
                    output check_word, output payload_byte, output last,
                    input ready);
    modport sink (input valid, input status, input out_channel,
                  input command_code, input frame_id, input payload_length,
                  input check_word, input payload_byte, input last,
                  output ready);
endinterface

@@ rtl/sld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer front end
// Per-channel parse state, configuration registers, store writes and jobs.
// ----------------------------------------------------------------------------
module sld_front (
    input  logic                            clk,
    input  logic                            rst_n,
    sld_in_if.sink                          items,
    input  logic                            cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [sld_pkg::NUM_CHANNELS-1:0] busy_mask,
    input  sld_pkg::q_stat_t                q_stat,
    output logic                            push,
    output sld_pkg::job_t                   job,
    output sld_pkg::mem_wr_t                mem_wr
);

    logic [sld_pkg::TIMER_W-1:0] timeout_reg;
    logic [sld_pkg::BYTE_W-1:0]  sync_reg;

    logic [sld_pkg::PHASE_W-1:0] phase_reg   [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::BYTE_W-1:0]  cmd_reg     [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::BYTE_W-1:0]  id_reg      [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::BYTE_W-1:0]  len_reg     [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::CNT_W-1:0]   count_reg   [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::BYTE_W-1:0]  chk_hi_reg  [sld_pkg::NUM_CHANNELS];
    logic [sld_pkg::TIMER_W-1:0] elapsed_reg [sld_pkg::NUM_CHANNELS];

    logic [sld_pkg::PHASE_W-1:0] phase_next;
    logic [sld_pkg::BYTE_W-1:0]  cmd_next;
    logic [sld_pkg::BYTE_W-1:0]  id_next;
    logic [sld_pkg::BYTE_W-1:0]  len_next;
    logic [sld_pkg::CNT_W-1:0]   count_next;
    logic [sld_pkg::BYTE_W-1:0]  chk_hi_next;
    logic [sld_pkg::TIMER_W-1:0] elapsed_next;

    logic [sld_pkg::CH_IDX_W-1:0]     ci;
    logic                             ch_ok;
    logic                             accept;
    logic                             hazard;
    logic                             do_job;
    logic                             do_wr;
    logic [sld_pkg::NUM_CHANNELS-1:0] busy_all;

    assign ci       = items.channel[sld_pkg::CH_IDX_W-1:0];
    assign ch_ok    = {1'b0, items.channel} < (sld_pkg::CH_W + 1)'(sld_pkg::NUM_CHANNELS);
    assign busy_all = busy_mask | q_stat.chan_mask;

    // A data byte may not overwrite a channel's store while its frame is read out.
    assign hazard = ch_ok && !items.kind && (phase_reg[ci] == sld_pkg::PH_DATA)
                    && busy_all[ci];
    assign items.ready = !q_stat.full && !hazard;
    assign accept = items.valid && items.ready;

    always_comb
    begin
        phase_next   = sld_pkg::PH_WAIT;
        cmd_next     = '0;
        id_next      = '0;
        len_next     = '0;
        count_next   = '0;
        chk_hi_next  = '0;
        elapsed_next = '0;
        do_job       = 1'b0;
        do_wr        = 1'b0;
        job.status   = sld_pkg::ST_OK;
        job.check    = '0;
        job.n_pay    = '0;
        if (ch_ok)
        begin
            phase_next   = phase_reg[ci];
            cmd_next     = cmd_reg[ci];
            id_next      = id_reg[ci];
            len_next     = len_reg[ci];
            count_next   = count_reg[ci];
            chk_hi_next  = chk_hi_reg[ci];
            elapsed_next = elapsed_reg[ci];
            if (items.kind)
            begin
                if (phase_reg[ci] != sld_pkg::PH_WAIT)
                begin
                    if (elapsed_reg[ci] >= timeout_reg)
                    begin
                        do_job     = 1'b1;
                        job.status = sld_pkg::ST_TIMEOUT;
                        phase_next = sld_pkg::PH_WAIT;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg[ci] + 1'b1;
                    end
                end
            end
            else
            begin
                unique case (phase_reg[ci])
                    sld_pkg::PH_WAIT:
                    begin
                        if (items.byte_value == sync_reg)
                        begin
                            cmd_next     = '0;
                            id_next      = '0;
                            len_next     = '0;
                            count_next   = '0;
                            chk_hi_next  = '0;
                            elapsed_next = '0;
                            phase_next   = sld_pkg::PH_CMD;
                        end
                    end
                    sld_pkg::PH_CMD:
                    begin
                        cmd_next   = items.byte_value;
                        phase_next = sld_pkg::PH_ID;
                    end
                    sld_pkg::PH_ID:
                    begin
                        id_next    = items.byte_value;
                        phase_next = sld_pkg::PH_LEN;
                    end
                    sld_pkg::PH_LEN:
                    begin
                        len_next = items.byte_value;
                        if (items.byte_value > sld_pkg::BYTE_W'(sld_pkg::MAX_PAYLOAD))
                        begin
                            do_job     = 1'b1;
                            job.status = sld_pkg::ST_OVERSIZE;
                            phase_next = sld_pkg::PH_WAIT;
                        end
                        else if (items.byte_value == '0)
                        begin
                            phase_next = sld_pkg::PH_CHK_HI;
                        end
                        else
                        begin
                            phase_next = sld_pkg::PH_DATA;
                        end
                    end
                    sld_pkg::PH_DATA:
                    begin
                        if (count_reg[ci] < sld_pkg::CNT_W'(sld_pkg::MAX_PAYLOAD))
                        begin
                            do_wr      = 1'b1;
                            count_next = count_reg[ci] + 1'b1;
                        end
                        if (sld_pkg::BYTE_W'(count_next) >= len_reg[ci])
                        begin
                            phase_next = sld_pkg::PH_CHK_HI;
                        end
                    end
                    sld_pkg::PH_CHK_HI:
                    begin
                        chk_hi_next = items.byte_value;
                        phase_next  = sld_pkg::PH_CHK_LO;
                    end
                    sld_pkg::PH_CHK_LO:
                    begin
                        do_job     = 1'b1;
                        phase_next = sld_pkg::PH_WAIT;
                        if (elapsed_reg[ci] > timeout_reg)
                        begin
                            job.status = sld_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            job.check = {chk_hi_reg[ci], items.byte_value};
                            job.n_pay = len_reg[ci][sld_pkg::CNT_W-1:0];
                        end
                    end
                    default:
                    begin
                        phase_next = sld_pkg::PH_WAIT;
                    end
                endcase
            end
        end
        job.channel = items.channel;
        job.command = cmd_next;
        job.id      = id_next;
        job.length  = len_next;
    end

    assign push = accept && do_job;

    always_comb
    begin
        mem_wr.en   = accept && do_wr;
        mem_wr.addr = sld_pkg::mem_addr(ci, count_reg[ci]);
        mem_wr.data = items.byte_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= sld_pkg::TIMEOUT_RESET;
            sync_reg    <= sld_pkg::SYNC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sld_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[sld_pkg::TIMER_W-1:0];
                sld_pkg::CFG_SYNC:    sync_reg    <= cfg_data[sld_pkg::BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sld_pkg::NUM_CHANNELS; i++)
            begin
                phase_reg[i] <= sld_pkg::PH_WAIT;
            end
        end
        else if (accept && ch_ok)
        begin
            phase_reg[ci] <= phase_next;
        end
    end

    // Frame fields are cleared by the sync byte before any use.
    always_ff @(posedge clk)
    begin
        if (accept && ch_ok)
        begin
            cmd_reg[ci]     <= cmd_next;
            id_reg[ci]      <= id_next;
            len_reg[ci]     <= len_next;
            count_reg[ci]   <= count_next;
            chk_hi_reg[ci]  <= chk_hi_next;
            elapsed_reg[ci] <= elapsed_next;
        end
    end

endmodule

@@ rtl/sld_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer job queue
// Small register queue of result jobs between the front and back ends.
// ----------------------------------------------------------------------------
module sld_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sld_pkg::job_t     push_job,
    input  logic              pop,
    output sld_pkg::job_t     head,
    output sld_pkg::q_stat_t  stat
);

    sld_pkg::job_t                    entry_reg [sld_pkg::QUEUE_DEPTH];
    logic [sld_pkg::QUEUE_DEPTH-1:0]  valid_reg;
    logic [sld_pkg::Q_IDX_W-1:0]      wr_ptr_reg;
    logic [sld_pkg::Q_IDX_W-1:0]      rd_ptr_reg;

    function automatic logic [sld_pkg::Q_IDX_W-1:0] ptr_inc(
        input logic [sld_pkg::Q_IDX_W-1:0] p);
        ptr_inc = (p == sld_pkg::Q_IDX_W'(sld_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        stat.full      = &valid_reg;
        stat.empty     = ~|valid_reg;
        stat.chan_mask = '0;
        for (int i = 0; i < sld_pkg::QUEUE_DEPTH; i++)
        begin
            if (valid_reg[i])
            begin
                stat.chan_mask[entry_reg[i].channel[sld_pkg::CH_IDX_W-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg[rd_ptr_reg] <= 1'b0;
                rd_ptr_reg            <= ptr_inc(rd_ptr_reg);
            end
            if (push)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg            <= ptr_inc(wr_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/sld_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer back end
// Payload store and result sequencer that walks a finished frame.
// ----------------------------------------------------------------------------
module sld_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sld_pkg::job_t                     head,
    input  logic                              q_empty,
    output logic                              pop,
    input  sld_pkg::mem_wr_t                  mem_wr,
    sld_out_if.source                         results,
    output logic [sld_pkg::NUM_CHANNELS-1:0]  busy_mask
);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_READ = 2'd1;
    localparam logic [1:0] BK_SHOW = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    sld_pkg::job_t              job_reg;
    logic [sld_pkg::CNT_W-1:0]  idx_reg;
    logic [sld_pkg::BYTE_W-1:0] rd_data_reg;
    logic [sld_pkg::BYTE_W-1:0] mem [sld_pkg::MEM_DEPTH];
    logic                       is_last;
    logic                       no_pay;

    assign pop     = (state_reg == BK_IDLE) && !q_empty;
    assign no_pay  = (job_reg.n_pay == '0);
    assign is_last = no_pay || (idx_reg == job_reg.n_pay - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_READ;
            BK_READ: state_next = BK_SHOW;
            BK_SHOW: if (results.ready) state_next = is_last ? BK_IDLE : BK_READ;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
            idx_reg <= '0;
        end
        else if ((state_reg == BK_SHOW) && results.ready && !is_last)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (state_reg == BK_READ)
        begin
            rd_data_reg <= mem[sld_pkg::mem_addr(job_reg.channel[sld_pkg::CH_IDX_W-1:0],
                                                 idx_reg)];
        end
    end

    always_comb
    begin
        busy_mask = '0;
        if (state_reg != BK_IDLE)
        begin
            busy_mask[job_reg.channel[sld_pkg::CH_IDX_W-1:0]] = 1'b1;
        end
    end

    assign results.valid          = (state_reg == BK_SHOW);
    assign results.status         = job_reg.status;
    assign results.out_channel    = job_reg.channel;
    assign results.command_code   = job_reg.command;
    assign results.frame_id       = job_reg.id;
    assign results.payload_length = job_reg.length;
    assign results.check_word     = job_reg.check;
    assign results.payload_byte   = no_pay ? '0 : rd_data_reg;
    assign results.last           = is_last;

endmodule

@@ rtl/sync_length_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length frame deframer core
// Per-channel sync byte, header, length and check word frame parser.
//
//   Port      Dir   Kind         Content
//   items     in    valid/ready  kind, channel, byte_value
//   results   out   valid/ready  status, header, check_word, payload_byte, last
//   cfg_*     in    write only   timeout_ms (index 0), sync_value (index 1)
//
// An input item is taken while the job queue has room; a data
// byte for a channel whose previous frame is still queued or being read out waits.
// Each result byte is read through the single payload store read port and then
// shown until taken; each job is first picked up from the queue.
// Reset returns every channel to waiting for sync; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    sld_in_if.sink                           items,
    sld_out_if.source                        results,
    input  logic                             cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                             push;
    logic                             pop;
    sld_pkg::job_t                    push_job;
    sld_pkg::job_t                    head;
    sld_pkg::q_stat_t                 q_stat;
    sld_pkg::mem_wr_t                 mem_wr;
    logic [sld_pkg::NUM_CHANNELS-1:0] busy_mask;

    sld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy_mask (busy_mask),
        .q_stat    (q_stat),
        .push      (push),
        .job       (push_job),
        .mem_wr    (mem_wr)
    );

    sld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    sld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_stat.empty),
        .pop       (pop),
        .mem_wr    (mem_wr),
        .results   (results),
        .busy_mask (busy_mask)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("Job pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("Job popped from an empty queue.");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> $onehot(busy_mask))
        else $error("Back end not busy on exactly one channel after taking a job.");

    a_store_safe: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !busy_mask[items.channel[sld_pkg::CH_IDX_W-1:0]]
                      && !q_stat.chan_mask[items.channel[sld_pkg::CH_IDX_W-1:0]])
        else $error("Payload store written for a channel still being read out.");

endmodule
